[hw/rtl/vft_pkg.sv]
// vft_pkg: shared types and constants for the VPIN flow toxicity block.
// No dependencies; used by every module under hw/rtl.
package vft_pkg;

  localparam int BUCKETS  = 64;                   // buckets held in the ring
  localparam int PRICE_W  = 32;
  localparam int SIZE_W   = 24;
  localparam int CFG_W    = 32;
  localparam int VOL_W    = 33;                   // open bucket volume
  localparam int FRAC_W   = 16;                   // Q0.16 result
  localparam int SLOT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int FILL_W   = $clog2(BUCKETS + 1);
  localparam int SUM_W    = VOL_W + SLOT_W + 1;   // sums over the ring
  localparam int CNT_W    = $clog2(FRAC_W);       // divider step counter
  localparam int Q_DEPTH  = 2;                    // front and result queues
  localparam int Q_AW     = 1;

  localparam logic [CFG_W-1:0] BUCKET_VOLUME_RST = CFG_W'(10000);

  typedef struct packed {
    logic [PRICE_W-1:0] bid_price;
    logic [PRICE_W-1:0] ask_price;
    logic [PRICE_W-1:0] trade_price;
    logic [SIZE_W-1:0]  trade_size;
  } tick_t;

  typedef struct packed {
    logic [FRAC_W-1:0] vpin_fraction;
    logic              vpin_valid;
    logic              bucket_closed;
  } result_t;

  // classified trade, front to back
  typedef struct packed {
    logic              is_buy;
    logic [SIZE_W-1:0] trade_size;
  } trade_t;

endpackage

[hw/rtl/vpin_flow_toxicity.sv]
// vpin_flow_toxicity: top level of the VPIN flow toxicity block.
// Depends on vft_pkg, vft_front, vft_back and vft_out_queue.
//
// Each market tick pushed on in_ yields exactly one request on out_: the
// current VPIN (sum of |buy-sell| over the last BUCKETS closed buckets divided
// by their total volume) as an unsigned Q0.16 fraction saturated at 65535,
// a valid flag (ring holds a bucket and volume is nonzero; fraction reads 0
// otherwise) and a flag telling whether this tick closed a bucket. A trade at
// or above the mid (2*price >= bid+ask, or either quote zero) is a buy. A
// tick of size zero changes nothing but still reports. Volume that overshoots
// the bucket size stays in the closing bucket. The front end classifies and
// queues up to two ticks, the back end processes one tick at a time, most
// of its work being the 16-step restoring divider that forms the quotient
// one bit per cycle. A two-entry result queue lets the back end finish while
// the consumer stalls. cfg_bucket_volume may be written at any time the block
// is idle (cfg_ready is always high); reset value 10000. No clearing pass is
// needed after reset: the ring is only read once every slot has been written.
module vpin_flow_toxicity (
  input  logic                      clk,
  input  logic                      rst_n,
  // tick input queue
  input  logic                      in_push,
  output logic                      in_full,
  input  vft_pkg::tick_t            in_tick,
  // result queue
  output logic                      out_empty,
  input  logic                      out_pop,
  output vft_pkg::result_t          out_result,
  // bucket size register
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [vft_pkg::CFG_W-1:0] cfg_bucket_volume
);

  logic              trade_valid;
  logic              trade_pop;
  vft_pkg::trade_t   trade;
  logic              res_push;
  logic              res_full;
  vft_pkg::result_t  res;

  assign cfg_ready = 1'b1;

  // classify buy/sell and buffer
  vft_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_tick     (in_tick),
    .trade_valid (trade_valid),
    .trade_pop   (trade_pop),
    .trade       (trade)
  );

  // bucket, ring, sums, divider
  vft_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_bucket_volume),
    .trade_valid (trade_valid),
    .trade_pop   (trade_pop),
    .trade       (trade),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  // decouple result from the consumer
  vft_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_push   (res_push),
    .res_full   (res_full),
    .res        (res),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (out_result)
  );

endmodule

[hw/rtl/vft_front.sv]
// vft_front: classifies each tick as buy or sell and queues it for the back end.
// Depends on vft_pkg.
module vft_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  vft_pkg::tick_t in_tick,
  output logic           trade_valid,
  input  logic           trade_pop,
  output vft_pkg::trade_t trade
);

  vft_pkg::trade_t             q_mem [vft_pkg::Q_DEPTH];
  logic [vft_pkg::Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [vft_pkg::Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [vft_pkg::Q_AW:0]      count_r, count_nxt;
  logic [vft_pkg::PRICE_W:0]   quote_sum;
  logic [vft_pkg::PRICE_W:0]   price_x2;
  logic                        no_quote;
  vft_pkg::trade_t             classed;
  logic                        do_push;
  logic                        do_pop;

  // buy when at or above mid; a missing side counts as buy
  assign quote_sum = {1'b0, in_tick.bid_price} + {1'b0, in_tick.ask_price};
  assign price_x2  = {in_tick.trade_price, 1'b0};
  assign no_quote  = (in_tick.bid_price == '0) || (in_tick.ask_price == '0);

  always_comb begin
    classed.is_buy     = no_quote || (price_x2 >= quote_sum);
    classed.trade_size = in_tick.trade_size;
  end

  assign in_full     = (count_r == (vft_pkg::Q_AW+1)'(vft_pkg::Q_DEPTH));
  assign trade_valid = (count_r != '0);
  assign trade       = q_mem[rd_ptr_r];
  assign do_push     = in_push && !in_full;
  assign do_pop      = trade_pop && trade_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= classed;
    end
  end

endmodule

[hw/rtl/vft_out_queue.sv]
// vft_out_queue: two-entry result queue in front of the out_ port.
// Depends on vft_pkg.
module vft_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_push,
  output logic             res_full,
  input  vft_pkg::result_t res,
  output logic             out_empty,
  input  logic             out_pop,
  output vft_pkg::result_t out_result
);

  vft_pkg::result_t          q_mem [vft_pkg::Q_DEPTH];
  logic [vft_pkg::Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [vft_pkg::Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [vft_pkg::Q_AW:0]    count_r, count_nxt;
  logic                      do_push;
  logic                      do_pop;

  assign res_full   = (count_r == (vft_pkg::Q_AW+1)'(vft_pkg::Q_DEPTH));
  assign out_empty  = (count_r == '0);
  assign out_result = q_mem[rd_ptr_r];
  assign do_push    = res_push && !res_full;
  assign do_pop     = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= res;
    end
  end

endmodule

[hw/rtl/vft_back.sv]
// vft_back: bucket accumulation, bucket ring, running sums and the VPIN divider.
// Depends on vft_pkg.
module vft_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [vft_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        trade_valid,
  output logic                        trade_pop,
  input  vft_pkg::trade_t             trade,
  input  logic                        res_full,
  output logic                        res_push,
  output vft_pkg::result_t            res
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVICT = 6'b000010,
    S_ADD   = 6'b000100,
    S_DINIT = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic [vft_pkg::VOL_W-1:0] buy;
    logic [vft_pkg::VOL_W-1:0] sell;
  } ring_entry_t;

  localparam int SUM_W = vft_pkg::SUM_W;
  localparam int VOL_W = vft_pkg::VOL_W;

  state_t                       state_r, state_nxt;
  logic [vft_pkg::CFG_W-1:0]    bucket_volume_r, bucket_volume_nxt;
  logic [VOL_W-1:0]             open_buy_r, open_buy_nxt;
  logic [VOL_W-1:0]             open_sell_r, open_sell_nxt;
  logic [VOL_W-1:0]             open_total_r, open_total_nxt;
  logic [vft_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [vft_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic [SUM_W-1:0]             sum_imb_r, sum_imb_nxt;
  logic [SUM_W-1:0]             sum_vol_r, sum_vol_nxt;
  logic                         closed_r, closed_nxt;
  logic                         valid_r, valid_nxt;
  logic                         sat_r, sat_nxt;
  logic [SUM_W-1:0]             rem_r, rem_nxt;
  logic [vft_pkg::FRAC_W-1:0]   quot_r, quot_nxt;
  logic [vft_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  ring_entry_t                  ring_mem [vft_pkg::BUCKETS];
  ring_entry_t                  ring_rd_r;
  logic                         ring_we;

  logic                         ring_full;
  logic [VOL_W-1:0]             add_buy, add_sell, add_total;
  logic [SUM_W:0]               rem_shift, rem_diff;
  logic                         rem_ge;

  function automatic logic [VOL_W-1:0] abs_diff(input logic [VOL_W-1:0] a,
                                                input logic [VOL_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  assign ring_full = (fill_r == vft_pkg::FILL_W'(vft_pkg::BUCKETS));
  assign add_buy   = open_buy_r + (trade.is_buy ? VOL_W'(trade.trade_size) : '0);
  assign add_sell  = open_sell_r + (trade.is_buy ? '0 : VOL_W'(trade.trade_size));
  assign add_total = open_total_r + VOL_W'(trade.trade_size);

  // one restoring step of the Q0.16 quotient
  assign rem_shift = {rem_r, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, sum_vol_r};
  assign rem_ge    = (rem_shift >= {1'b0, sum_vol_r});

  assign trade_pop = (state_r == S_IDLE) && trade_valid;
  assign res_push  = (state_r == S_OUT) && !res_full;
  assign ring_we   = (state_r == S_EVICT);

  always_comb begin
    res.bucket_closed = closed_r;
    res.vpin_valid    = valid_r;
    if (!valid_r) begin
      res.vpin_fraction = '0;
    end else if (sat_r) begin
      res.vpin_fraction = '1;
    end else begin
      res.vpin_fraction = quot_r;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    bucket_volume_nxt = cfg_we ? cfg_data : bucket_volume_r;
    open_buy_nxt      = open_buy_r;
    open_sell_nxt     = open_sell_r;
    open_total_nxt    = open_total_r;
    slot_nxt          = slot_r;
    fill_nxt          = fill_r;
    sum_imb_nxt       = sum_imb_r;
    sum_vol_nxt       = sum_vol_r;
    closed_nxt        = closed_r;
    valid_nxt         = valid_r;
    sat_nxt           = sat_r;
    rem_nxt           = rem_r;
    quot_nxt          = quot_r;
    cnt_nxt           = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (trade_valid) begin
          closed_nxt = 1'b0;
          state_nxt  = S_DINIT;
          if (trade.trade_size != '0) begin
            open_buy_nxt   = add_buy;
            open_sell_nxt  = add_sell;
            open_total_nxt = add_total;
            if (add_total >= VOL_W'(bucket_volume_r)) begin
              closed_nxt = 1'b1;
              state_nxt  = S_EVICT;
            end
          end
        end
      end
      S_EVICT: begin
        // ring_rd_r holds the slot about to be overwritten
        if (ring_full) begin
          sum_imb_nxt = sum_imb_r - SUM_W'(abs_diff(ring_rd_r.buy, ring_rd_r.sell));
          sum_vol_nxt = sum_vol_r - SUM_W'(ring_rd_r.buy) - SUM_W'(ring_rd_r.sell);
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        sum_imb_nxt    = sum_imb_r + SUM_W'(abs_diff(open_buy_r, open_sell_r));
        sum_vol_nxt    = sum_vol_r + SUM_W'(open_buy_r) + SUM_W'(open_sell_r);
        open_buy_nxt   = '0;
        open_sell_nxt  = '0;
        open_total_nxt = '0;
        slot_nxt       = (slot_r == vft_pkg::SLOT_W'(vft_pkg::BUCKETS - 1)) ?
                         '0 : slot_r + 1'b1;
        if (!ring_full) begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        valid_nxt = (fill_r != '0) && (sum_vol_r != '0);
        sat_nxt   = (sum_imb_r >= sum_vol_r);
        rem_nxt   = sum_imb_r;
        quot_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt   = rem_ge ? rem_diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
        quot_nxt  = {quot_r[vft_pkg::FRAC_W-2:0], rem_ge};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == vft_pkg::CNT_W'(vft_pkg::FRAC_W - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      bucket_volume_r <= vft_pkg::BUCKET_VOLUME_RST;
      open_buy_r      <= '0;
      open_sell_r     <= '0;
      open_total_r    <= '0;
      slot_r          <= '0;
      fill_r          <= '0;
      sum_imb_r       <= '0;
      sum_vol_r       <= '0;
      closed_r        <= 1'b0;
      valid_r         <= 1'b0;
      sat_r           <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      bucket_volume_r <= bucket_volume_nxt;
      open_buy_r      <= open_buy_nxt;
      open_sell_r     <= open_sell_nxt;
      open_total_r    <= open_total_nxt;
      slot_r          <= slot_nxt;
      fill_r          <= fill_nxt;
      sum_imb_r       <= sum_imb_nxt;
      sum_vol_r       <= sum_vol_nxt;
      closed_r        <= closed_nxt;
      valid_r         <= valid_nxt;
      sat_r           <= sat_nxt;
    end
  end

  // divider datapath, no reset needed
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
  end

  // bucket ring: one write port, registered read at the write slot
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[slot_r] <= '{buy: open_buy_r, sell: open_sell_r};
    end
    ring_rd_r <= ring_mem[slot_r];
  end

  // imbalance can never exceed volume, in any state
  assert property (@(posedge clk) disable iff (!rst_n) sum_imb_r <= sum_vol_r)
    else $error("ring imbalance sum exceeds volume sum");

  assert property (@(posedge clk) disable iff (!rst_n)
    open_total_r == open_buy_r + open_sell_r)
    else $error("open bucket total out of step with buy and sell");

  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= vft_pkg::FILL_W'(vft_pkg::BUCKETS))
    else $error("ring fill count past capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r <= sum_vol_r))
    else $error("divider remainder above divisor");

  assert property (@(posedge clk) disable iff (!rst_n)
    trade_pop |=> (state_r == S_EVICT || state_r == S_DINIT))
    else $error("accepted trade did not enter bucket update");

endmodule
